FILE: sv/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// lzwe_pkg
// Shared constants and types of the variable-width LZW encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwe_pkg;

    localparam int MAX_CODE_WIDTH_DEF  = 16;
    localparam int SLOT_INDEX_BITS_DEF = 17;

    localparam int CODE_BITS  = 16;
    localparam int WIDTH_BITS = 5;
    localparam int ACC_BITS   = CODE_BITS + 7;
    localparam int HELD_BITS  = 5;

    localparam logic [8:0] CODE_CLEAR      = 9'd256;
    localparam logic [8:0] CODE_STOP       = 9'd257;
    localparam logic [8:0] CODE_FIRST_FREE = 9'd258;
    localparam logic [WIDTH_BITS-1:0] WIDTH_START = 5'd9;

    localparam logic [31:0] HASH_MUL_A = 32'd2654435761;
    localparam logic [31:0] HASH_MUL_B = 32'd40503;

    localparam int EPOCH_BITS     = 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    typedef struct packed {
        logic [CODE_BITS-1:0]  code;
        logic [WIDTH_BITS-1:0] width;
        logic                  item_end;
        logic                  flush;
    } t_cmd;

endpackage

`default_nettype wire

FILE: sv/lzw_variable_width_encoder.sv
// ----------------------------------------------------------------------------
// lzw_variable_width_encoder
// Variable-width (9 to MAX_CODE_WIDTH bit) LZW encoder with LSB-first packing.
// ----------------------------------------------------------------------------
//  channel | ports                                   | word
//  --------+-----------------------------------------+---------------------------
//  in      | i_valid / o_ready                       | i_data_byte, i_last_byte
//  out     | o_valid / i_ready                       | o_packed_byte, o_run_end,
//          |                                         | o_stream_end
//
//  A byte passes S_IDLE, S_OPEN, S_DECIDE and S_LAST when it starts a prefix;
//  a hit adds S_RD and S_CMP, a miss also S_MISS, and each extra probe of
//  the single-port slot memory repeats S_RD and S_CMP; a dictionary-full
//  CLEAR adds S_CLR and a last byte adds S_STOP. After reset, and on every
//  15th epoch change (dictionary clear or stream end), a wipe pass over all
//  2^SLOT_INDEX_BITS slots runs with o_ready low. Code commands wait in a
//  4-entry queue that stalls the front when full; the packer takes a code
//  only after sending the words of the last one, and stalls only on i_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_variable_width_encoder import lzwe_pkg::*; #(
    parameter int MAX_CODE_WIDTH  = MAX_CODE_WIDTH_DEF,
    parameter int SLOT_INDEX_BITS = SLOT_INDEX_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_packed_byte,
    output logic            o_run_end,
    output logic            o_stream_end
);

    logic w_push, w_full, w_pop, w_empty;
    t_cmd w_push_cmd, w_head_cmd;

    lzwe_front #(
        .MAX_CODE_WIDTH  (MAX_CODE_WIDTH),
        .SLOT_INDEX_BITS (SLOT_INDEX_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd),
        .i_full      (w_full)
    );

    lzwe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty)
    );

    lzwe_packer u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_cmd         (w_head_cmd),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_packed_byte (o_packed_byte),
        .o_run_end     (o_run_end),
        .o_stream_end  (o_stream_end)
    );

endmodule

`default_nettype wire

FILE: sv/lzwe_front.sv
// ----------------------------------------------------------------------------
// lzwe_front
// Accepts input words, runs the hash dictionary and issues code commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwe_front import lzwe_pkg::*; #(
    parameter int MAX_CODE_WIDTH  = MAX_CODE_WIDTH_DEF,
    parameter int SLOT_INDEX_BITS = SLOT_INDEX_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_push,
    output t_cmd            o_cmd,
    input  wire logic       i_full
);

    localparam int SLOT_COUNT = 1 << SLOT_INDEX_BITS;
    localparam int MW         = MAX_CODE_WIDTH;
    localparam int ENTRY_BITS = EPOCH_BITS + MW + 8 + MW;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_OPEN   = 10'b0000000010,
        S_DECIDE = 10'b0000000100,
        S_RD     = 10'b0000001000,
        S_CMP    = 10'b0000010000,
        S_MISS   = 10'b0000100000,
        S_CLR    = 10'b0001000000,
        S_LAST   = 10'b0010000000,
        S_STOP   = 10'b0100000000,
        S_WIPE   = 10'b1000000000
    } t_state;

    t_state                      r_state, n_state;
    logic [7:0]                  r_byte, n_byte;
    logic                        r_last, n_last;
    logic [MW-1:0]               r_prefix, n_prefix;
    logic                        r_present, n_present;
    logic [MW:0]                 r_next, n_next;
    logic [WIDTH_BITS-1:0]       r_width, n_width;
    logic                        r_open, n_open;
    logic [EPOCH_BITS-1:0]       r_epoch, n_epoch;
    logic [SLOT_INDEX_BITS-1:0]  r_slot, n_slot;
    logic [SLOT_INDEX_BITS-1:0]  r_cnt, n_cnt;
    logic                        r_can_ins, n_can_ins;
    logic                        r_wret, n_wret;
    logic [ENTRY_BITS-1:0]       r_rdata;

    logic [ENTRY_BITS-1:0]       mem [SLOT_COUNT];
    logic                        w_we;
    logic [ENTRY_BITS-1:0]       w_wdata;

    logic [EPOCH_BITS-1:0]       e_epoch;
    logic [MW-1:0]               e_prefix;
    logic [7:0]                  e_byte;
    logic [MW-1:0]               e_code;
    logic [31:0]                 w_hash;
    logic                        w_full_code;

    assign e_code   = r_rdata[MW-1:0];
    assign e_byte   = r_rdata[MW+7:MW];
    assign e_prefix = r_rdata[2*MW+7:MW+8];
    assign e_epoch  = r_rdata[ENTRY_BITS-1:2*MW+8];

    assign w_hash = (32'(r_prefix) * HASH_MUL_A) + (32'(r_byte) * HASH_MUL_B);
    assign w_full_code = r_next[MW];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_slot] <= w_wdata;
        end
        r_rdata <= mem[r_slot];
    end

    always_comb begin
        n_state   = r_state;
        n_byte    = r_byte;
        n_last    = r_last;
        n_prefix  = r_prefix;
        n_present = r_present;
        n_next    = r_next;
        n_width   = r_width;
        n_open    = r_open;
        n_epoch   = r_epoch;
        n_slot    = r_slot;
        n_cnt     = r_cnt;
        n_can_ins = r_can_ins;
        n_wret    = r_wret;
        o_ready   = 1'b0;
        o_push    = 1'b0;
        o_cmd     = '0;
        w_we      = 1'b0;
        w_wdata   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_byte  = i_data_byte;
                    n_last  = i_last_byte;
                    n_state = S_OPEN;
                end
            end
            S_OPEN: begin
                if (r_open) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.code     = CODE_BITS'(CODE_CLEAR);
                    o_cmd.width    = r_width;
                    o_cmd.item_end = !r_last;
                    o_push         = !i_full;
                    if (!i_full) begin
                        n_open  = 1'b1;
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (!r_present) begin
                    n_prefix  = MW'(r_byte);
                    n_present = 1'b1;
                    n_state   = S_LAST;
                end else begin
                    n_slot  = w_hash[SLOT_INDEX_BITS-1:0];
                    n_cnt   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (e_epoch == r_epoch) begin
                    if (e_prefix == r_prefix && e_byte == r_byte) begin
                        n_prefix = e_code;
                        n_state  = S_LAST;
                    end else begin
                        n_slot = r_slot + 1'b1;
                        n_cnt  = r_cnt + 1'b1;
                        if (r_cnt == '1) begin
                            n_can_ins = 1'b0;
                            n_state   = S_MISS;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end else begin
                    n_can_ins = 1'b1;
                    n_state   = S_MISS;
                end
            end
            S_MISS: begin
                o_cmd.code     = CODE_BITS'(r_prefix);
                o_cmd.width    = r_width;
                o_cmd.item_end = !w_full_code && !r_last;
                o_push         = !i_full;
                if (!i_full) begin
                    if (!w_full_code) begin
                        w_we    = r_can_ins;
                        w_wdata = {r_epoch, r_prefix, r_byte, r_next[MW-1:0]};
                        n_next  = r_next + 1'b1;
                        if (r_next >= ((MW+1)'(1) << r_width) &&
                            r_width < WIDTH_BITS'(MW)) begin
                            n_width = r_width + 1'b1;
                        end
                        n_prefix = MW'(r_byte);
                        n_state  = S_LAST;
                    end else begin
                        n_state = S_CLR;
                    end
                end
            end
            S_CLR: begin
                o_cmd.code     = CODE_BITS'(CODE_CLEAR);
                o_cmd.width    = r_width;
                o_cmd.item_end = !r_last;
                o_push         = !i_full;
                if (!i_full) begin
                    n_next   = (MW+1)'(CODE_FIRST_FREE);
                    n_width  = WIDTH_START;
                    n_prefix = MW'(r_byte);
                    if (r_epoch == '1) begin
                        n_slot  = '0;
                        n_wret  = 1'b1;
                        n_state = S_WIPE;
                    end else begin
                        n_epoch = r_epoch + 1'b1;
                        n_state = S_LAST;
                    end
                end
            end
            S_LAST: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.code  = CODE_BITS'(r_prefix);
                    o_cmd.width = r_width;
                    o_push      = !i_full;
                    if (!i_full) begin
                        n_state = S_STOP;
                    end
                end
            end
            S_STOP: begin
                o_cmd.code     = CODE_BITS'(CODE_STOP);
                o_cmd.width    = r_width;
                o_cmd.item_end = 1'b1;
                o_cmd.flush    = 1'b1;
                o_push         = !i_full;
                if (!i_full) begin
                    n_prefix  = '0;
                    n_present = 1'b0;
                    n_next    = (MW+1)'(CODE_FIRST_FREE);
                    n_width   = WIDTH_START;
                    n_open    = 1'b0;
                    if (r_epoch == '1) begin
                        n_slot  = '0;
                        n_wret  = 1'b0;
                        n_state = S_WIPE;
                    end else begin
                        n_epoch = r_epoch + 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_WIPE: begin
                w_we   = 1'b1;
                n_slot = r_slot + 1'b1;
                if (r_slot == '1) begin
                    n_epoch = EPOCH_BITS'(1);
                    n_state = r_wret ? S_LAST : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_WIPE;
            r_prefix  <= '0;
            r_present <= 1'b0;
            r_next    <= (MW+1)'(CODE_FIRST_FREE);
            r_width   <= WIDTH_START;
            r_open    <= 1'b0;
            r_epoch   <= '0;
            r_slot    <= '0;
            r_cnt     <= '0;
            r_can_ins <= 1'b0;
            r_wret    <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_prefix  <= n_prefix;
            r_present <= n_present;
            r_next    <= n_next;
            r_width   <= n_width;
            r_open    <= n_open;
            r_epoch   <= n_epoch;
            r_slot    <= n_slot;
            r_cnt     <= n_cnt;
            r_can_ins <= n_can_ins;
            r_wret    <= n_wret;
            r_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

`default_nettype wire

FILE: sv/lzwe_queue.sv
// ----------------------------------------------------------------------------
// lzwe_queue
// Short command FIFO between dictionary front and bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwe_queue import lzwe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty
);

    t_cmd                      r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wp, r_rp;
    logic [QUEUE_CNT_BITS-1:0] r_cnt;

    assign o_full  = (r_cnt == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/lzwe_packer.sv
// ----------------------------------------------------------------------------
// lzwe_packer
// Packs variable-width codes LSB-first into output words.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwe_packer import lzwe_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_cmd  i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [7:0] o_packed_byte,
    output logic       o_run_end,
    output logic       o_stream_end
);

    logic [ACC_BITS-1:0]  r_acc, n_acc;
    logic [HELD_BITS-1:0] r_held, n_held;
    logic                 r_busy, n_busy;
    logic                 r_item_end, n_item_end;
    logic                 r_flush, n_flush;
    logic                 r_ovalid, n_ovalid;
    logic [7:0]           r_obyte, n_obyte;
    logic                 r_orun, n_orun;
    logic                 r_oend, n_oend;

    logic                 w_out_free;
    logic                 w_have;
    logic [HELD_BITS-1:0] w_rem;
    logic                 w_fin;

    assign w_out_free = !r_ovalid || i_ready;
    assign o_pop      = !r_busy && !i_empty;
    assign w_have     = (r_held >= HELD_BITS'(8)) || (r_flush && r_held != '0);
    assign w_rem      = (r_held >= HELD_BITS'(8)) ? r_held - HELD_BITS'(8) : '0;
    assign w_fin      = r_flush ? (w_rem == '0) : (w_rem < HELD_BITS'(8));

    always_comb begin
        n_acc      = r_acc;
        n_held     = r_held;
        n_busy     = r_busy;
        n_item_end = r_item_end;
        n_flush    = r_flush;
        n_ovalid   = r_ovalid && !i_ready;
        n_obyte    = r_obyte;
        n_orun     = r_orun;
        n_oend     = r_oend;
        if (o_pop) begin
            n_acc      = r_acc | (ACC_BITS'(i_cmd.code) << r_held);
            n_held     = r_held + HELD_BITS'(i_cmd.width);
            n_busy     = 1'b1;
            n_item_end = i_cmd.item_end;
            n_flush    = i_cmd.flush;
        end else if (r_busy) begin
            if (!w_have) begin
                n_busy = 1'b0;
                if (r_flush) begin
                    n_acc = '0;
                end
            end else if (w_out_free) begin
                n_ovalid = 1'b1;
                n_obyte  = r_acc[7:0];
                n_orun   = r_item_end && w_fin;
                n_oend   = r_flush && w_fin;
                n_acc    = r_acc >> 8;
                n_held   = w_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_held     <= '0;
            r_busy     <= 1'b0;
            r_item_end <= 1'b0;
            r_flush    <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_acc      <= n_acc;
            r_held     <= n_held;
            r_busy     <= n_busy;
            r_item_end <= n_item_end;
            r_flush    <= n_flush;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_obyte <= n_obyte;
        r_orun  <= n_orun;
        r_oend  <= n_oend;
    end

    assign o_valid       = r_ovalid;
    assign o_packed_byte = r_obyte;
    assign o_run_end     = r_orun;
    assign o_stream_end  = r_oend;

endmodule

`default_nettype wire

FILE: sv/lzwe_checker.sv
// ----------------------------------------------------------------------------
// lzwe_checker
// Port-level checks of the LZW encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwe_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_packed_byte,
    input wire logic       i_run_end,
    input wire logic       i_stream_end
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |=> i_in_valid)
        else $error("input valid dropped before accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_packed_byte))
        else $error("output word changed while stalled");

    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stream_end |-> i_run_end)
        else $error("stream end without run end");

    a_wipe_ready: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_in_ready)
        else $error("input ready during wipe after reset");

    a_rst_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind lzw_variable_width_encoder lzwe_checker u_lzwe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_valid),
    .i_in_ready    (o_ready),
    .i_out_valid   (o_valid),
    .i_out_ready   (i_ready),
    .i_packed_byte (o_packed_byte),
    .i_run_end     (o_run_end),
    .i_stream_end  (o_stream_end)
);

`default_nettype wire
